### rtl/sddw_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and arithmetic helpers of the split decimal display writer.
package sddw_pkg;

  localparam int unsigned PctW      = 8;
  localparam int unsigned PosW      = 32;
  localparam int unsigned AddrW     = 4;
  localparam int unsigned CodeW     = 4;
  localparam int unsigned BcdW      = 16;   // four decimal digits of the position
  localparam int unsigned NibW      = 4;    // position bits folded in per cycle
  localparam int unsigned ConvSteps = PosW / NibW;
  localparam int unsigned ConvCntW  = $clog2(ConvSteps);
  localparam int unsigned WriteCnt  = 8;
  localparam int unsigned WrIdxW    = $clog2(WriteCnt);
  localparam int unsigned DefQueueDepth = 2;

  localparam logic [PctW-1:0]  PctMax    = 8'd199;
  localparam logic [PctW-1:0]  PctHund   = 8'd100;
  localparam logic [PctW-1:0]  PctTen    = 8'd10;
  localparam logic [CodeW-1:0] CodeBlank = 4'hF;
  localparam logic [CodeW-1:0] CodeDash  = 4'hA;
  localparam logic [CodeW-1:0] CodeOne   = 4'h1;

  // write slot indexes, address is slot plus one
  localparam logic [WrIdxW-1:0] SlotPos0  = 3'd0;
  localparam logic [WrIdxW-1:0] SlotPos1  = 3'd1;
  localparam logic [WrIdxW-1:0] SlotPos2  = 3'd2;
  localparam logic [WrIdxW-1:0] SlotPos3  = 3'd3;
  localparam logic [WrIdxW-1:0] SlotUnits = 3'd4;
  localparam logic [WrIdxW-1:0] SlotTens  = 3'd5;
  localparam logic [WrIdxW-1:0] SlotHund  = 3'd6;
  localparam logic [WrIdxW-1:0] SlotDash  = 3'd7;
  localparam logic [AddrW-1:0]  AddrLast  = 4'd8;

  typedef struct packed {
    logic [BcdW-1:0]  pos_bcd;    // position modulo 10000, BCD
    logic [CodeW-1:0] units;
    logic [CodeW-1:0] tens;
    logic [CodeW-1:0] hund;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Fold one nibble, MSB first, into a four-digit BCD accumulator.
  // Digits above the thousands are dropped, which keeps the value modulo 10000.
  function automatic logic [BcdW-1:0] bcd_step(input logic [BcdW-1:0] acc,
                                               input logic [NibW-1:0] nib);
    logic [BcdW-1:0] a;
    a = acc;
    for (int b = NibW - 1; b >= 0; b--) begin
      for (int d = 0; d < BcdW / 4; d++) begin
        if (a[d*4 +: 4] >= 4'd5) begin
          a[d*4 +: 4] = a[d*4 +: 4] + 4'd3;
        end
      end
      a = {a[BcdW-2:0], nib[b]};
    end
    return a;
  endfunction

  // Split a saturated percentage into its three display codes with blanking.
  function automatic entry_t pct_codes(input logic [PctW-1:0] pct);
    entry_t          e;
    logic [PctW-1:0] sat;
    logic [6:0]      r;
    logic [14:0]     prod;
    logic [3:0]      t;
    logic [6:0]      t10;
    sat  = (pct > PctMax) ? PctMax : pct;
    r    = (sat >= PctHund) ? 7'(sat - PctHund) : sat[6:0];
    prod = 15'(r) * 15'd205;        // r / 10 for r below 100
    t    = prod[14:11];
    t10  = 7'({3'd0, t} * 7'd10);
    e.pos_bcd = '0;
    e.units   = 4'(r - t10);
    e.tens    = (sat >= PctTen) ? t : CodeBlank;
    e.hund    = (sat >= PctHund) ? CodeOne : CodeBlank;
    return e;
  endfunction

endpackage

### rtl/split_decimal_display_writer.sv
`timescale 1ns / 1ps
// Top level of the split decimal display writer: front, queue and back end.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------
//  item    | in        | start, busy        | pwm_percent_i, position_count_i
//  write   | out       | result_strobe_o    | register_address_o, digit_code_o,
//          |           |                    | last_write_o
//
// An item is taken at an edge where start is high and busy is low. The front end
// folds the position into four BCD digits four bits a cycle, holding its last step
// while the queue is full; an item may be taken in the very cycle the previous one
// finishes, and the queue lets the front end convert it while the back end plays
// out the eight writes of the last. The first write of an item reaches the ports
// through the front end's conversion registers, the queue and the back end's slot
// registers; the other seven writes follow in consecutive cycles, addresses 1 to 8.
// The receiver cannot stall; busy rises only while the front end is converting or
// the queue between front and back is full. Reset clears all control state.
module split_decimal_display_writer #(
  parameter int unsigned QueueDepth = sddw_pkg::DefQueueDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [sddw_pkg::PctW-1:0]  pwm_percent_i,
  input  logic [sddw_pkg::PosW-1:0]  position_count_i,
  output logic                       result_strobe_o,
  output logic [sddw_pkg::AddrW-1:0] register_address_o,
  output logic [sddw_pkg::CodeW-1:0] digit_code_o,
  output logic                       last_write_o
);
  import sddw_pkg::*;

  // front to queue
  logic      push;
  entry_t    push_entry;
  // queue to back
  logic      pop;
  entry_t    pop_entry;
  q_status_t q_status;

  // Accept, saturate and split the percentage, and convert the position.
  sddw_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .pwm_percent_i    (pwm_percent_i),
    .position_count_i (position_count_i),
    .q_status_i       (q_status),
    .push_o           (push),
    .push_entry_o     (push_entry)
  );

  // Hold prepared items so the front can take the next one while writes go out.
  sddw_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .pop_entry_o  (pop_entry),
    .status_o     (q_status)
  );

  // Advance through the eight register writes of each item.
  sddw_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .q_status_i         (q_status),
    .pop_entry_i        (pop_entry),
    .pop_o              (pop),
    .result_strobe_o    (result_strobe_o),
    .register_address_o (register_address_o),
    .digit_code_o       (digit_code_o),
    .last_write_o       (last_write_o)
  );

endmodule

### rtl/sddw_front.sv
`timescale 1ns / 1ps
// Front end: accept items, prepare percentage codes, fold the position into BCD.
module sddw_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [sddw_pkg::PctW-1:0] pwm_percent_i,
  input  logic [sddw_pkg::PosW-1:0] position_count_i,
  input  sddw_pkg::q_status_t       q_status_i,
  output logic                      push_o,
  output sddw_pkg::entry_t          push_entry_o
);
  import sddw_pkg::*;

  logic                active_q, active_d;
  logic [ConvCntW-1:0] cnt_q, cnt_d;
  logic [PosW-1:0]     shift_q, shift_d;
  logic [BcdW-1:0]     bcd_q, bcd_d;
  entry_t              codes_q, codes_d;
  logic [BcdW-1:0]     bcd_next;
  logic                last_step, accept, advance;

  always_comb begin
    bcd_next  = bcd_step(bcd_q, shift_q[PosW-1 -: NibW]);
    last_step = active_q && (cnt_q == ConvCntW'(ConvSteps - 1));
    push_o    = last_step && !q_status_i.full;
    busy      = active_q && !push_o;
    accept    = start && !busy;
    advance   = active_q && !last_step;

    push_entry_o         = codes_q;
    push_entry_o.pos_bcd = bcd_next;

    active_d = active_q;
    cnt_d    = cnt_q;
    shift_d  = shift_q;
    bcd_d    = bcd_q;
    codes_d  = codes_q;
    if (accept) begin
      active_d = 1'b1;
      cnt_d    = '0;
      shift_d  = position_count_i;
      bcd_d    = '0;
      codes_d  = pct_codes(pwm_percent_i);
    end else if (advance) begin
      cnt_d   = cnt_q + 1'b1;
      shift_d = {shift_q[PosW-NibW-1:0], {NibW{1'b0}}};
      bcd_d   = bcd_next;
    end else if (push_o) begin
      active_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    bcd_q   <= bcd_d;
    codes_q <= codes_d;
  end

  a_push_only_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> active_q && (cnt_q == ConvCntW'(ConvSteps - 1)))
    else $error("push outside the final conversion step");
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_step && q_status_i.full |=> active_q && $stable(bcd_q))
    else $error("conversion moved while queue was full");
  a_busy_while_converting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |-> busy)
    else $error("ready in mid-conversion");

endmodule

### rtl/sddw_queue.sv
`timescale 1ns / 1ps
// Small FIFO of prepared items between front and back.
module sddw_queue #(
  parameter int unsigned Depth = sddw_pkg::DefQueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  sddw_pkg::entry_t    push_entry_i,
  input  logic                pop_i,
  output sddw_pkg::entry_t    pop_entry_o,
  output sddw_pkg::q_status_t status_o
);
  import sddw_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : PtrW'(p + 1'b1);
  endfunction

  always_comb begin
    status_o.full  = (cnt_q == CntW'(Depth));
    status_o.empty = (cnt_q == '0);
    pop_entry_o    = mem_q[rd_q];
    wr_d  = push_i ? ptr_inc(wr_q) : wr_q;
    rd_d  = pop_i ? ptr_inc(rd_q) : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_entry_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !status_o.full)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !status_o.empty)
    else $error("pop from empty queue");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count out of range");

endmodule

### rtl/sddw_back.sv
`timescale 1ns / 1ps
// Back end: play one queued item out as eight digit-register writes.
module sddw_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sddw_pkg::q_status_t        q_status_i,
  input  sddw_pkg::entry_t           pop_entry_i,
  output logic                       pop_o,
  output logic                       result_strobe_o,
  output logic [sddw_pkg::AddrW-1:0] register_address_o,
  output logic [sddw_pkg::CodeW-1:0] digit_code_o,
  output logic                       last_write_o
);
  import sddw_pkg::*;

  logic              valid_q, valid_d;
  logic [WrIdxW-1:0] idx_q, idx_d;
  entry_t            cur_q;
  logic              at_end;

  always_comb begin
    at_end  = valid_q && (idx_q == SlotDash);
    pop_o   = !q_status_i.empty && (!valid_q || at_end);
    valid_d = pop_o ? 1'b1 : (at_end ? 1'b0 : valid_q);
    idx_d   = pop_o ? '0 : (valid_q ? WrIdxW'(idx_q + 1'b1) : idx_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= pop_entry_i;
    end
  end

  always_comb begin
    result_strobe_o    = valid_q;
    register_address_o = AddrW'(idx_q) + 1'b1;
    last_write_o       = at_end;
    unique case (idx_q)
      SlotPos0:  digit_code_o = cur_q.pos_bcd[3:0];
      SlotPos1:  digit_code_o = cur_q.pos_bcd[7:4];
      SlotPos2:  digit_code_o = cur_q.pos_bcd[11:8];
      SlotPos3:  digit_code_o = cur_q.pos_bcd[15:12];
      SlotUnits: digit_code_o = cur_q.units;
      SlotTens:  digit_code_o = cur_q.tens;
      SlotHund:  digit_code_o = cur_q.hund;
      SlotDash:  digit_code_o = CodeDash;
      default:   digit_code_o = CodeDash;
    endcase
  end

  a_last_is_eighth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_write_o |-> result_strobe_o && (register_address_o == AddrLast))
    else $error("last write not on address eight");
  a_run_unbroken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !at_end |=> valid_q && (idx_q == WrIdxW'($past(idx_q) + 1'b1)))
    else $error("write run broken");
  a_run_starts_at_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> valid_q && (idx_q == SlotPos0))
    else $error("run does not start at address one");

endmodule

### tb/split_decimal_display_writer_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the split decimal display writer: bursty items, write-by-write checks.
module split_decimal_display_writer_test;
  import sddw_pkg::*;

  // Idle cycles allowed with nothing taken and no write seen. The slowest
  // correct stretch is the sender's longest gap plus the block's latency.
  localparam int unsigned IdleLimit   = 2000;
  // Cycles to keep watching once every expected write has come: enough to
  // catch a stray write from an item that should have produced none.
  localparam int unsigned DrainCycles = 24;
  localparam int unsigned RandomItems = 450;
  localparam int unsigned MaxGap      = 19;
  localparam int unsigned MaxBurst    = 12;

  // One register write as the display driver sees it.
  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [CodeW-1:0] code;
    logic             last;
  } display_write_t;

  logic             clk_i;
  logic             rst_ni            = 1'b0;
  logic             start             = 1'b0;
  logic             busy;
  logic [PctW-1:0]  pwm_percent_i     = '0;
  logic [PosW-1:0]  position_count_i  = '0;
  logic             result_strobe_o;
  logic [AddrW-1:0] register_address_o;
  logic [CodeW-1:0] digit_code_o;
  logic             last_write_o;

  display_write_t pending_writes[$];   // writes still owed by the block, oldest first
  int unsigned    fault_count = 0;
  int unsigned    burst_left  = 0;     // items left in the current burst

  split_decimal_display_writer dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .pwm_percent_i      (pwm_percent_i),
    .position_count_i   (position_count_i),
    .result_strobe_o    (result_strobe_o),
    .register_address_o (register_address_o),
    .digit_code_o       (digit_code_o),
    .last_write_o       (last_write_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Work out the eight writes one item causes and append them to the queue:
  // four position digits (modulo 10000, least significant first), then the
  // saturated percentage as units, tens and hundreds with leading zeros
  // blanked, then the dash.
  function automatic void predict_display_writes(input logic [PctW-1:0] pct,
                                                 input logic [PosW-1:0] pos);
    int unsigned    pct_sat;
    int unsigned    pos_rem;
    display_write_t w;
    pct_sat = (pct > PctMax) ? PctMax : pct;
    pos_rem = pos % 10000;
    for (int k = 0; k < 4; k++) begin
      w.addr  = AddrW'(k + 1);
      w.code  = CodeW'(pos_rem % 10);
      w.last  = 1'b0;
      pos_rem = pos_rem / 10;
      pending_writes.push_back(w);
    end
    w.addr = AddrW'(5);
    w.code = CodeW'(pct_sat % 10);
    pending_writes.push_back(w);
    w.addr = AddrW'(6);
    w.code = (pct_sat >= PctTen) ? CodeW'((pct_sat / 10) % 10) : CodeBlank;
    pending_writes.push_back(w);
    w.addr = AddrW'(7);
    w.code = (pct_sat >= PctHund) ? CodeOne : CodeBlank;
    pending_writes.push_back(w);
    w.addr = AddrLast;
    w.code = CodeDash;
    w.last = 1'b1;
    pending_writes.push_back(w);
  endfunction

  // Offer one item and hold it until the block takes it. Called at a rising
  // edge. Between most bursts drop start for a random gap; within a burst keep it
  // high so back-to-back items meet every phase of the conversion.
  task automatic send_item(input logic [PctW-1:0] pct, input logic [PosW-1:0] pos);
    int unsigned gap;
    if (burst_left == 0) begin
      // a third of the bursts follow on with no gap at all
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, MaxGap);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, MaxBurst);
    end
    burst_left--;
    start            <= 1'b1;
    pwm_percent_i    <= pct;
    position_count_i <= pos;
    // busy is read before the block updates it, so this is the value the
    // block itself saw at this edge
    do @(posedge clk_i); while (busy);
    predict_display_writes(pct, pos);
  endtask

  // Percentages around every blanking and saturation boundary.
  task automatic test_percentage_range();
    logic [PctW-1:0] pcts[10] = '{8'd0, 8'd1, 8'd9, 8'd10, 8'd99,
                                  8'd100, 8'd199, 8'd200, 8'd254, 8'd255};
    foreach (pcts[i]) send_item(pcts[i], PosW'(i * 1111));
  endtask

  // Positions at the edges of the modulus and of the 32-bit range.
  task automatic test_position_range();
    logic [PosW-1:0] posns[9] = '{32'd0, 32'd1, 32'd9999, 32'd10000, 32'd10001,
                                  32'd12345678, 32'h8000_0000, 32'hFFFF_FFFE,
                                  32'hFFFF_FFFF};
    foreach (posns[i]) send_item(PctW'(i * 31), posns[i]);
  endtask

  // Random items: mostly uniform fields, with a share aimed at the
  // boundaries and at small positions so that carries across digits show up.
  task automatic test_random_items();
    logic [PctW-1:0] pct;
    logic [PosW-1:0] pos;
    logic [PctW-1:0] pct_edges[8] = '{8'd0, 8'd9, 8'd10, 8'd99, 8'd100,
                                      8'd199, 8'd200, 8'd255};
    for (int n = 0; n < RandomItems; n++) begin
      case ($urandom_range(0, 3))
        0:       pct = pct_edges[$urandom_range(0, 7)];
        default: pct = PctW'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 3))
        0:       pos = PosW'($urandom_range(0, 19999));
        1:       pos = PosW'($urandom_range(0, 9)) * 10000 + 9999;
        default: pos = $urandom();
      endcase
      send_item(pct, pos);
    end
  endtask

  // Compare every write with the oldest one owed; flag writes nobody asked for.
  always @(posedge clk_i) begin
    display_write_t want;
    if (rst_ni && result_strobe_o) begin
      if (pending_writes.size() == 0) begin
        $error("write with none expected: address %0d code %0d last %0d",
               register_address_o, digit_code_o, last_write_o);
        fault_count++;
      end else begin
        want = pending_writes.pop_front();
        if (register_address_o !== want.addr) begin
          $error("register_address: expected %0d, got %0d", want.addr, register_address_o);
          fault_count++;
        end
        if (digit_code_o !== want.code) begin
          $error("digit_code: expected %0d, got %0d", want.code, digit_code_o);
          fault_count++;
        end
        if (last_write_o !== want.last) begin
          $error("last_write: expected %0d, got %0d", want.last, last_write_o);
          fault_count++;
        end
      end
    end
  end

  // Watchdog: end the run if neither side moves for too long.
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (start && !busy) || result_strobe_o) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    // hold reset low from the start, then release it at an edge
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_percentage_range();
    test_position_range();
    test_random_items();

    // drain: wait for every owed write, then watch a little longer for strays
    start <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (fault_count == 0 && pending_writes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
